/* rtl/hlt_pkg.sv */
// Shared types and constants of the heartbeat liveness table.
// Used by hlt_entry_mem, hlt_entry_unit and heartbeat_liveness_table; no dependencies.
package hlt_pkg;

  localparam int unsigned MAX_PEERS_DEF = 16;
  localparam int unsigned LOST_CODE_DEF = 0;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATE_W  = 4;
  localparam int unsigned MISSED_W = 8;
  localparam int unsigned RCOUNT_W = 8;
  localparam int unsigned OUT_W    = 5;

  localparam logic [MISSED_W-1:0] MISSED_MAX = '1;

  typedef enum logic {
    REQ_HEARTBEAT = 1'b0,
    REQ_TICK      = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [STATE_W-1:0]  state;
    logic [MISSED_W-1:0] missed;
  } entry_t;

  // Request held for the whole walk over the table.
  typedef struct packed {
    logic                tick;
    logic                upd;
    logic [ID_W-1:0]     peer_id;
    logic [STATE_W-1:0]  peer_state;
    logic [RCOUNT_W-1:0] rcount;
  } req_t;

  // Verdict of the entry unit on one table entry.
  typedef struct packed {
    entry_t ent;
    logic   match;
    logic   mark;
    logic   keep;
  } verdict_t;

endpackage

/* rtl/heartbeat_liveness_table.sv */
// Top level of the heartbeat liveness table: request sequencer and result registers.
// Depends on hlt_pkg, hlt_entry_mem and hlt_entry_unit.
//
// Usage. A request is taken at a rising edge where start_i is high and busy_o is low.
// req_type_i selects a heartbeat (refresh or append peer_id_i, age the others, mark
// stale entries lost) or a tick (drop lost entries and close the gaps in order).
// The sequencer walks the table one entry per cycle through a single entry unit,
// with the store read in the cycle before the write-back. The result appears on
// the result ports, with done_o high for exactly one cycle, once the walk is over
// and the sequencer has passed through its finishing state; with an empty table
// there is nothing to walk and the scan state hands straight on to that state.
// busy_o falls in the cycle that shows the result, so the next request can be taken
// at the edge that takes the result. The receiver cannot hold results off.
// cfg_we_i with cfg_wdata_i writes node_id_set; it must be written only while idle,
// which the block does not enforce. Reset empties the table (occupancy zero) and clears
// node_id_set; the entry store is not cleared: only entries below the occupancy are used.
module heartbeat_liveness_table #(
  parameter int unsigned MAX_PEERS = hlt_pkg::MAX_PEERS_DEF,
  parameter int unsigned LOST_CODE = hlt_pkg::LOST_CODE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [hlt_pkg::ID_W-1:0]      peer_id_i,
  input  logic [hlt_pkg::STATE_W-1:0]   peer_state_i,
  input  logic [hlt_pkg::RCOUNT_W-1:0]  reported_count_i,
  output logic                          done_o,
  output logic                          inserted_new_o,
  output logic                          insert_dropped_o,
  output logic [hlt_pkg::OUT_W-1:0]     marked_lost_o,
  output logic                          size_mismatch_o,
  output logic [hlt_pkg::OUT_W-1:0]     removed_count_o,
  output logic [hlt_pkg::OUT_W-1:0]     entries_used_o
);

  localparam int unsigned AW   = $clog2(MAX_PEERS);
  localparam int unsigned OW   = $clog2(MAX_PEERS + 1);
  localparam int unsigned CMPW = (OW > hlt_pkg::RCOUNT_W) ? OW : hlt_pkg::RCOUNT_W;
  localparam logic [OW-1:0] MaxOcc = OW'(MAX_PEERS);
  localparam logic [hlt_pkg::STATE_W-1:0] Lost = hlt_pkg::STATE_W'(LOST_CODE);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic              node_set_q, node_set_d;
  hlt_pkg::req_t     req_q, req_d;
  logic [OW-1:0]     occ_q, occ_d;
  logic [OW-1:0]     rd_q, rd_d;
  logic [OW-1:0]     wr_q, wr_d;
  logic [OW-1:0]     cnt_q, cnt_d;
  logic              known_q, known_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic              done_q, done_d;
  logic              ins_q, ins_d;
  logic              drop_q, drop_d;
  logic [OW-1:0]     marked_q, marked_d;
  logic              mism_q, mism_d;
  logic [OW-1:0]     removed_q, removed_d;
  logic [OW-1:0]     used_q, used_d;

  logic              issue;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  hlt_pkg::entry_t   mem_wdata;
  hlt_pkg::entry_t   mem_rdata;
  hlt_pkg::verdict_t verdict;
  logic              append;
  logic              unknown;
  logic [OW-1:0]     occ_new;
  logic [OW-1:0]     cnt_new;

  hlt_entry_mem #(
    .DEPTH  (MAX_PEERS),
    .ADDR_W (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  hlt_entry_unit #(
    .LOST_CODE (LOST_CODE)
  ) u_unit (
    .req_i     (req_q),
    .ent_i     (mem_rdata),
    .verdict_o (verdict)
  );

  always_comb begin
    state_d    = state_q;
    node_set_d = cfg_we_i ? cfg_wdata_i : node_set_q;
    req_d      = req_q;
    occ_d      = occ_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    cnt_d      = cnt_q;
    known_d    = known_q;
    pend_d     = pend_q;
    pidx_d     = pidx_q;
    done_d     = 1'b0;
    ins_d      = ins_q;
    drop_d     = drop_q;
    marked_d   = marked_q;
    mism_d     = mism_q;
    removed_d  = removed_q;
    used_d     = used_q;
    mem_we     = 1'b0;
    mem_waddr  = pidx_q;
    mem_wdata  = verdict.ent;

    issue   = (state_q == S_SCAN) && (rd_q < occ_q);
    unknown = req_q.upd && !known_q;
    append  = unknown && (occ_q < MaxOcc);
    occ_new = occ_q + OW'(append);
    cnt_new = cnt_q + OW'(append && (req_q.rcount == '0));

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d.tick       = (req_type_i == hlt_pkg::REQ_TICK);
          req_d.upd        = (peer_id_i > hlt_pkg::ID_W'(1)) && node_set_q;
          req_d.peer_id    = peer_id_i;
          req_d.peer_state = peer_state_i;
          req_d.rcount     = reported_count_i;
          rd_d    = '0;
          wr_d    = '0;
          cnt_d   = '0;
          known_d = 1'b0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        pend_d = issue;
        pidx_d = rd_q[AW-1:0];
        if (issue) begin
          rd_d = rd_q + OW'(1);
        end
        if (pend_q) begin
          if (req_q.tick) begin
            // Kept entries slide down to the write pointer, which never passes the read one.
            if (verdict.keep) begin
              mem_we    = 1'b1;
              mem_waddr = wr_q[AW-1:0];
              mem_wdata = mem_rdata;
              wr_d      = wr_q + OW'(1);
            end else begin
              cnt_d = cnt_q + OW'(1);
            end
          end else begin
            mem_we = 1'b1;
            if (verdict.match) begin
              known_d = 1'b1;
            end
            if (verdict.mark) begin
              cnt_d = cnt_q + OW'(1);
            end
          end
        end
        if (!issue && !pend_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (req_q.tick) begin
          occ_d     = wr_q;
          ins_d     = 1'b0;
          drop_d    = 1'b0;
          marked_d  = '0;
          mism_d    = 1'b0;
          removed_d = cnt_q;
          used_d    = wr_q;
        end else begin
          // A newly appended peer has a zero counter, so it is marked only for a zero count.
          mem_we           = append;
          mem_waddr        = occ_q[AW-1:0];
          mem_wdata.id     = req_q.peer_id;
          mem_wdata.state  = (req_q.rcount == '0) ? Lost : req_q.peer_state;
          mem_wdata.missed = '0;
          occ_d     = occ_new;
          ins_d     = append;
          drop_d    = unknown && !append;
          marked_d  = cnt_new;
          mism_d    = node_set_q &&
                      (CMPW'(occ_new - cnt_new) != CMPW'(req_q.rcount));
          removed_d = '0;
          used_d    = occ_new;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      node_set_q <= 1'b0;
      occ_q      <= '0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
      req_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      cnt_q      <= '0;
      known_q    <= 1'b0;
      pidx_q     <= '0;
      ins_q      <= 1'b0;
      drop_q     <= 1'b0;
      marked_q   <= '0;
      mism_q     <= 1'b0;
      removed_q  <= '0;
      used_q     <= '0;
    end else begin
      state_q    <= state_d;
      node_set_q <= node_set_d;
      occ_q      <= occ_d;
      pend_q     <= pend_d;
      done_q     <= done_d;
      req_q      <= req_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      cnt_q      <= cnt_d;
      known_q    <= known_d;
      pidx_q     <= pidx_d;
      ins_q      <= ins_d;
      drop_q     <= drop_d;
      marked_q   <= marked_d;
      mism_q     <= mism_d;
      removed_q  <= removed_d;
      used_q     <= used_d;
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign inserted_new_o   = ins_q;
  assign insert_dropped_o = drop_q;
  assign marked_lost_o    = hlt_pkg::OUT_W'(marked_q);
  assign size_mismatch_o  = mism_q;
  assign removed_count_o  = hlt_pkg::OUT_W'(removed_q);
  assign entries_used_o   = hlt_pkg::OUT_W'(used_q);

  // The table never holds more peers than it has room for.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= MaxOcc)
    else $error("occupancy above table depth");

  // A result is only shown once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // A heartbeat either appends or drops a new peer, never both.
  a_ins_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(inserted_new_o && insert_dropped_o))
    else $error("peer both appended and dropped");

  // A tick never moves the write pointer ahead of the read pointer.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (wr_q <= rd_q))
    else $error("compaction write ahead of read");

endmodule

/* rtl/hlt_entry_mem.sv */
// Entry store of the heartbeat liveness table: one write and one registered read per cycle.
// Depends on hlt_pkg for the entry type.
module hlt_entry_mem #(
  parameter int unsigned DEPTH  = hlt_pkg::MAX_PEERS_DEF,
  parameter int unsigned ADDR_W = $clog2(hlt_pkg::MAX_PEERS_DEF)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  hlt_pkg::entry_t     wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output hlt_pkg::entry_t     rdata_o
);

  hlt_pkg::entry_t mem_q [DEPTH];
  hlt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/hlt_entry_unit.sv */
// Shared per-entry unit: ages or refreshes one entry, decides marking and tick retention.
// Depends on hlt_pkg for the request, entry and verdict types.
module hlt_entry_unit #(
  parameter int unsigned LOST_CODE = hlt_pkg::LOST_CODE_DEF
) (
  input  hlt_pkg::req_t     req_i,
  input  hlt_pkg::entry_t   ent_i,
  output hlt_pkg::verdict_t verdict_o
);

  localparam logic [hlt_pkg::STATE_W-1:0] Lost = hlt_pkg::STATE_W'(LOST_CODE);

  logic                          match;
  logic [hlt_pkg::STATE_W-1:0]   state_upd;
  logic [hlt_pkg::MISSED_W-1:0]  missed_upd;
  logic                          mark;

  always_comb begin
    match = req_i.upd && (ent_i.id == req_i.peer_id);
    state_upd  = match ? req_i.peer_state : ent_i.state;
    if (match) begin
      missed_upd = '0;
    end else if (req_i.upd && (ent_i.missed != hlt_pkg::MISSED_MAX)) begin
      missed_upd = ent_i.missed + hlt_pkg::MISSED_W'(1);
    end else begin
      missed_upd = ent_i.missed;
    end
    // Counter at least reported count plus one is the same as strictly above it.
    mark = (missed_upd > req_i.rcount) || (req_i.rcount == '0);

    verdict_o.ent.id     = ent_i.id;
    verdict_o.ent.state  = mark ? Lost : state_upd;
    verdict_o.ent.missed = missed_upd;
    verdict_o.match      = match;
    verdict_o.mark       = mark;
    verdict_o.keep       = (ent_i.state != Lost);
  end

endmodule

/* verif/heartbeat_liveness_table_test.sv */
// Self-checking testbench for heartbeat_liveness_table: directed and random requests,
// predicted with a table model of its own and compared field by field on every done_o.
// Depends on hlt_pkg and the heartbeat_liveness_table RTL.
module heartbeat_liveness_table_test;

  localparam int unsigned TABLE_DEPTH = hlt_pkg::MAX_PEERS_DEF;
  localparam logic [hlt_pkg::STATE_W-1:0] LOST_STATE = hlt_pkg::STATE_W'(hlt_pkg::LOST_CODE_DEF);
  localparam int unsigned POOL_SIZE = 20;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef enum logic [1:0] {
    OP_REQUEST,
    OP_CONFIG,
    OP_DRAIN,
    OP_PACE
  } op_kind_e;

  typedef struct {
    op_kind_e                     kind;
    hlt_pkg::req_type_e           req;
    logic [hlt_pkg::ID_W-1:0]     peer_id;
    logic [hlt_pkg::STATE_W-1:0]  peer_state;
    logic [hlt_pkg::RCOUNT_W-1:0] rcount;
    logic                         cfg_value;
    int unsigned                  idle_pct;
  } stim_op_t;

  typedef struct packed {
    logic                      inserted_new;
    logic                      insert_dropped;
    logic [hlt_pkg::OUT_W-1:0] marked_lost;
    logic                      size_mismatch;
    logic [hlt_pkg::OUT_W-1:0] removed_count;
    logic [hlt_pkg::OUT_W-1:0] entries_used;
  } liveness_outcome_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_wdata_i = 1'b0;
  logic                         start_i = 1'b0;
  logic                         req_type_i = 1'b0;
  logic [hlt_pkg::ID_W-1:0]     peer_id_i = '0;
  logic [hlt_pkg::STATE_W-1:0]  peer_state_i = '0;
  logic [hlt_pkg::RCOUNT_W-1:0] reported_count_i = '0;
  logic                         busy_o;
  logic                         done_o;
  logic                         inserted_new_o;
  logic                         insert_dropped_o;
  logic [hlt_pkg::OUT_W-1:0]    marked_lost_o;
  logic                         size_mismatch_o;
  logic [hlt_pkg::OUT_W-1:0]    removed_count_o;
  logic [hlt_pkg::OUT_W-1:0]    entries_used_o;

  // Shadow copy of the peer table and of node_id_set.
  logic [hlt_pkg::ID_W-1:0]     peer_ids    [TABLE_DEPTH];
  logic [hlt_pkg::STATE_W-1:0]  peer_states [TABLE_DEPTH];
  logic [hlt_pkg::MISSED_W-1:0] peer_missed [TABLE_DEPTH];
  int unsigned                  occupied = 0;
  logic                         node_id_known = 1'b0;

  stim_op_t                     pending_q[$];
  liveness_outcome_t            outcome_q[$];
  stim_op_t                     in_flight;
  logic [hlt_pkg::ID_W-1:0]     peer_pool [POOL_SIZE];
  int unsigned                  idle_pct = 0;
  int unsigned                  fault_count = 0;
  int unsigned                  stall_cycles = 0;

  heartbeat_liveness_table DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .peer_id_i        (peer_id_i),
    .peer_state_i     (peer_state_i),
    .reported_count_i (reported_count_i),
    .done_o           (done_o),
    .inserted_new_o   (inserted_new_o),
    .insert_dropped_o (insert_dropped_o),
    .marked_lost_o    (marked_lost_o),
    .size_mismatch_o  (size_mismatch_o),
    .removed_count_o  (removed_count_o),
    .entries_used_o   (entries_used_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic liveness_outcome_t table_apply(stim_op_t op);
    liveness_outcome_t res;
    logic              known;
    int unsigned       wr;
    int unsigned       marked;
    res = '0;
    known = 1'b0;
    wr = 0;
    marked = 0;
    if (op.req == hlt_pkg::REQ_TICK) begin
      for (int rd = 0; rd < occupied; rd++) begin
        if (peer_states[rd] == LOST_STATE) begin
          res.removed_count = res.removed_count + 1'b1;
        end else begin
          peer_ids[wr] = peer_ids[rd];
          peer_states[wr] = peer_states[rd];
          peer_missed[wr] = peer_missed[rd];
          wr++;
        end
      end
      occupied = wr;
    end else begin
      if (op.peer_id > 1 && node_id_known) begin
        for (int i = 0; i < occupied; i++) begin
          if (peer_ids[i] == op.peer_id) begin
            known = 1'b1;
            peer_states[i] = op.peer_state;
            peer_missed[i] = '0;
          end else if (peer_missed[i] != hlt_pkg::MISSED_MAX) begin
            peer_missed[i] = peer_missed[i] + 1'b1;
          end
        end
        if (!known) begin
          if (occupied < TABLE_DEPTH) begin
            peer_ids[occupied] = op.peer_id;
            peer_states[occupied] = op.peer_state;
            peer_missed[occupied] = '0;
            occupied++;
            res.inserted_new = 1'b1;
          end else begin
            res.insert_dropped = 1'b1;
          end
        end
      end
      // A zero reported count marks every entry, already lost ones included.
      for (int i = 0; i < occupied; i++) begin
        if (op.rcount == 0 || int'(peer_missed[i]) > int'(op.rcount)) begin
          peer_states[i] = LOST_STATE;
          marked++;
        end
      end
      res.marked_lost = hlt_pkg::OUT_W'(marked);
      res.size_mismatch = node_id_known && (int'(occupied) - int'(marked) != int'(op.rcount));
    end
    res.entries_used = hlt_pkg::OUT_W'(occupied);
    return res;
  endfunction

  function automatic void push_request(hlt_pkg::req_type_e req, int unsigned pid,
                                       int unsigned pst, int unsigned rc);
    stim_op_t op;
    op = '{kind: OP_REQUEST, req: req, peer_id: hlt_pkg::ID_W'(pid),
           peer_state: hlt_pkg::STATE_W'(pst), rcount: hlt_pkg::RCOUNT_W'(rc),
           cfg_value: 1'b0, idle_pct: 0};
    pending_q.insert(pending_q.size(), op);
  endfunction

  // Control entries: a register write, a pause until the table is quiet, or a new pacing.
  function automatic void push_op(op_kind_e kind, int unsigned arg);
    stim_op_t op;
    op = '{kind: kind, req: hlt_pkg::REQ_HEARTBEAT, peer_id: '0, peer_state: '0, rcount: '0,
           cfg_value: arg[0], idle_pct: arg};
    pending_q.insert(pending_q.size(), op);
  endfunction

  // Mostly heartbeats from a small pool of peers, so that refreshes, appends, a full
  // table and ageing all occur; some ignored or unknown ids and some ticks.
  function automatic void random_request();
    int unsigned pid;
    int unsigned pst;
    int unsigned rc;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) pid = $urandom_range(0, 1);
    else if (pick < 12) pid = $urandom_range(0, 65535);
    else pid = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
    pst = ($urandom_range(0, 99) < 10) ? LOST_STATE : $urandom_range(0, 15);
    pick = $urandom_range(0, 99);
    if (pick < 5) rc = 0;
    else if (pick < 25) rc = $urandom_range(0, 255);
    else if (pick < 55) rc = $urandom_range(0, TABLE_DEPTH + 1);
    else rc = $urandom_range(1, 12);
    if ($urandom_range(0, 99) < 12) push_request(hlt_pkg::REQ_TICK, pid, pst, rc);
    else push_request(hlt_pkg::REQ_HEARTBEAT, pid, pst, rc);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk_i) begin : request_driver
    stim_op_t head;
    logic     accepted;
    logic     launch;
    logic     write_cfg;
    logic     quiet;
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      launch = 1'b0;
      write_cfg = 1'b0;
      if (cfg_we_i) node_id_known = cfg_wdata_i;
      if (accepted) outcome_q.insert(outcome_q.size(), table_apply(in_flight));
      quiet = !accepted && !start_i && !busy_o && !done_o && outcome_q.size() == 0;
      if (start_i && !accepted) begin
        launch = 1'b1;
      end else if (pending_q.size() != 0) begin
        head = pending_q[0];
        case (head.kind)
          OP_REQUEST: begin
            if ($urandom_range(0, 99) >= idle_pct) begin
              launch = 1'b1;
              in_flight = head;
              void'(pending_q.pop_front());
              req_type_i <= head.req;
              peer_id_i <= head.peer_id;
              peer_state_i <= head.peer_state;
              reported_count_i <= head.rcount;
            end
          end
          OP_CONFIG: begin
            if (quiet) begin
              write_cfg = 1'b1;
              cfg_wdata_i <= head.cfg_value;
              void'(pending_q.pop_front());
            end
          end
          OP_DRAIN: begin
            if (quiet) void'(pending_q.pop_front());
          end
          default: begin
            idle_pct = head.idle_pct;
            void'(pending_q.pop_front());
          end
        endcase
      end
      start_i <= launch;
      cfg_we_i <= write_cfg;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    liveness_outcome_t want;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %h", $time,
                 {inserted_new_o, insert_dropped_o, marked_lost_o, size_mismatch_o,
                  removed_count_o, entries_used_o});
        fault_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("inserted_new", want.inserted_new, inserted_new_o);
        check_field("insert_dropped", want.insert_dropped, insert_dropped_o);
        check_field("marked_lost", want.marked_lost, marked_lost_o);
        check_field("size_mismatch", want.size_mismatch, size_mismatch_o);
        check_field("removed_count", want.removed_count, removed_count_o);
        check_field("entries_used", want.entries_used, entries_used_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned pace_table [4];
    int unsigned batch;
    pace_table = '{0, 54, 0, 23};
    peer_pool[0] = 16'd2;
    peer_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      peer_pool[i] = hlt_pkg::ID_W'($urandom_range(2, 65535));
    end

    // Without an own id nothing is updated, but the marking still runs.
    push_op(OP_CONFIG, 0);
    push_request(hlt_pkg::REQ_HEARTBEAT, 5, 3, 0);
    push_request(hlt_pkg::REQ_TICK, 0, 0, 0);
    push_op(OP_CONFIG, 1);
    push_request(hlt_pkg::REQ_HEARTBEAT, 0, 4'hF, 255);
    push_request(hlt_pkg::REQ_HEARTBEAT, 1, 4'hF, 255);
    push_request(hlt_pkg::REQ_HEARTBEAT, 2, 1, 255);
    push_request(hlt_pkg::REQ_HEARTBEAT, 16'hFFFF, 4'hF, 255);
    push_request(hlt_pkg::REQ_HEARTBEAT, 2, 5, 0);
    push_request(hlt_pkg::REQ_TICK, 16'hFFFF, 4'hF, 255);
    // Fill the table, one peer reporting the lost code, then overflow it.
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      push_request(hlt_pkg::REQ_HEARTBEAT, 100 + k, (k == 7) ? LOST_STATE : 6, 255);
    end
    push_request(hlt_pkg::REQ_HEARTBEAT, 999, 7, 128);
    push_request(hlt_pkg::REQ_HEARTBEAT, 100, 2, 3);
    push_request(hlt_pkg::REQ_TICK, 0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      push_op(OP_CONFIG, (ph == 1) ? 0 : 1);
      push_op(OP_PACE, pace_table[ph]);
      batch = (ph == 1) ? 60 : 255;
      for (int n = 0; n < batch; n++) begin
        if (ph == 2 && n == 100) push_op(OP_DRAIN, 0);
        random_request();
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || outcome_q.size() != 0 || start_i || busy_o) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d", $time,
               outcome_q.size(), outcome_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hlt_pkg.sv
rtl/hlt_entry_mem.sv
rtl/hlt_entry_unit.sv
rtl/heartbeat_liveness_table.sv
verif/heartbeat_liveness_table_test.sv
